[sv/qrs_pkg.sv]
// qrs_pkg: shared widths, case codes and stage payload types for the quadratic root solver
// no dependencies; imported by every module of the block
package qrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // coefficient magnitude, products and discriminant
    localparam int MAG_W   = WORD_BITS;
    localparam int PROD_W  = 2 * WORD_BITS;
    localparam int DISC_W  = 2 * WORD_BITS + 2;
    // integer square root of the discriminant scaled by 2^(2*FRAC_BITS)
    localparam int SQRT_W  = WORD_BITS + FRAC_BITS + 1;
    localparam int SQREM_W = SQRT_W + 1;
    // numerator -b*2^F (or -c*2^F) before and after adding the root
    localparam int BASE_W  = WORD_BITS + FRAC_BITS;
    localparam int NUM_W   = SQRT_W + 1;
    // divisor 2a (or b)
    localparam int DIV_W   = WORD_BITS + 1;

    // register stages from an accepted item to its result
    localparam int LATENCY = 4 + SQRT_W + NUM_W;

    typedef enum logic [1:0] {
        CASE_NONE = 2'd0,
        CASE_ONE  = 2'd1,
        CASE_TWO  = 2'd2,
        CASE_INF  = 2'd3
    } rcase_t;

    // payload travelling down the square root cells
    typedef struct packed {
        rcase_t               rcase;
        logic [BASE_W-1:0]    num;
        logic                 num_neg;
        logic [DIV_W-1:0]     dv;
        logic                 dv_neg;
        logic [DISC_W-1:0]    rad;
        logic [SQREM_W-1:0]   rem;
        logic [SQRT_W-1:0]    root;
    } sqc_t;

    // payload travelling down the divider cells, two lanes
    typedef struct packed {
        rcase_t               rcase;
        logic [DIV_W-1:0]     dv;
        logic                 neg1;
        logic                 neg2;
        logic [NUM_W-1:0]     n1;
        logic [NUM_W-1:0]     n2;
        logic [DIV_W-1:0]     r1;
        logic [DIV_W-1:0]     r2;
    } dvc_t;

endpackage

[sv/qrs_front.sv]
// qrs_front: coefficient magnitudes, products, discriminant and case decode (two stages)
// depends on qrs_pkg
module qrs_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]   coef_a,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]   coef_b,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]   coef_c,
    output logic                                   vld,
    output qrs_pkg::sqc_t                          data
);
    import qrs_pkg::*;

    logic              v1_reg;
    logic [MAG_W-1:0]  ma_reg, mb_reg, mc_reg;
    logic              na_reg, nb_reg, nc_reg;
    logic [PROD_W-1:0] p_reg, q_reg;
    logic [MAG_W-1:0]  ma_next, mb_next, mc_next;

    logic              v2_reg;
    sqc_t              d2_reg, d2_next;

    logic [DISC_W-1:0] p_ext, q4, disc;
    logic              disc_neg;

    assign ma_next = coef_a[WORD_BITS-1] ? MAG_W'(-coef_a) : MAG_W'(coef_a);
    assign mb_next = coef_b[WORD_BITS-1] ? MAG_W'(-coef_b) : MAG_W'(coef_b);
    assign mc_next = coef_c[WORD_BITS-1] ? MAG_W'(-coef_c) : MAG_W'(coef_c);

    // stage 1: magnitudes and the two products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        mc_reg <= mc_next;
        na_reg <= coef_a[WORD_BITS-1];
        nb_reg <= coef_b[WORD_BITS-1];
        nc_reg <= coef_c[WORD_BITS-1];
        p_reg  <= PROD_W'(mb_next) * PROD_W'(mb_next);
        q_reg  <= PROD_W'(ma_next) * PROD_W'(mc_next);
    end

    // stage 2: discriminant and case decode
    always_comb
    begin
        p_ext    = DISC_W'(p_reg);
        q4       = {q_reg, 2'b00};
        disc     = '0;
        disc_neg = 1'b0;
        if ((na_reg != nc_reg) || (mc_reg == '0))
        begin
            disc = p_ext + q4;
        end
        else if (p_ext >= q4)
        begin
            disc = p_ext - q4;
        end
        else
        begin
            disc_neg = 1'b1;
        end
    end

    always_comb
    begin
        d2_next         = '0;
        d2_next.rcase   = CASE_NONE;
        if (ma_reg == '0)
        begin
            if (mb_reg == '0)
            begin
                d2_next.rcase = (mc_reg == '0) ? CASE_INF : CASE_NONE;
            end
            else
            begin
                // linear: -c / b
                d2_next.rcase   = CASE_ONE;
                d2_next.num     = {mc_reg, {FRAC_BITS{1'b0}}};
                d2_next.num_neg = (mc_reg != '0) && !nc_reg;
                d2_next.dv      = DIV_W'(mb_reg);
                d2_next.dv_neg  = nb_reg;
            end
        end
        else
        begin
            d2_next.num     = {mb_reg, {FRAC_BITS{1'b0}}};
            d2_next.num_neg = (mb_reg != '0) && !nb_reg;
            d2_next.dv      = {ma_reg, 1'b0};
            d2_next.dv_neg  = na_reg;
            if (disc_neg)
            begin
                d2_next.rcase = CASE_NONE;
            end
            else if (disc == '0)
            begin
                d2_next.rcase = CASE_ONE;
            end
            else
            begin
                d2_next.rcase = CASE_TWO;
                d2_next.rad   = disc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d2_reg <= d2_next;
    end

    assign vld  = v2_reg;
    assign data = d2_reg;

endmodule

[sv/qrs_sqrt_cell.sv]
// qrs_sqrt_cell: one root bit of the bit-pair integer square root
// depends on qrs_pkg
module qrs_sqrt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  qrs_pkg::sqc_t d_in,
    output logic          vld,
    output qrs_pkg::sqc_t d_out
);
    import qrs_pkg::*;

    logic                 vld_reg;
    sqc_t                 d_reg, d_next;
    logic [SQREM_W+1:0]   rem_sh, trial, diff;
    logic                 ge;

    always_comb
    begin
        rem_sh = {d_in.rem, d_in.rad[DISC_W-1 -: 2]};
        trial  = (SQREM_W+2)'({d_in.root, 2'b01});
        diff   = rem_sh - trial;
        ge     = rem_sh >= trial;
        d_next      = d_in;
        d_next.rad  = {d_in.rad[DISC_W-3:0], 2'b00};
        d_next.rem  = ge ? diff[SQREM_W-1:0] : rem_sh[SQREM_W-1:0];
        d_next.root = {d_in.root[SQRT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign vld   = vld_reg;
    assign d_out = d_reg;

endmodule

[sv/qrs_join.sv]
// qrs_join: forms the two signed numerators -b*2^F -/+ sqrt and loads the divider
// depends on qrs_pkg
module qrs_join (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  qrs_pkg::sqc_t d_in,
    output logic          vld,
    output qrs_pkg::dvc_t d_out
);
    import qrs_pkg::*;

    logic                    vld_reg;
    dvc_t                    d_reg, d_next;
    logic signed [NUM_W:0]   ns, sv, v1, v2;

    always_comb
    begin
        ns = d_in.num_neg ? -$signed((NUM_W+1)'(d_in.num)) : $signed((NUM_W+1)'(d_in.num));
        sv = $signed((NUM_W+1)'(d_in.root));
        v1 = ns - sv;
        v2 = ns + sv;
        d_next       = '0;
        d_next.rcase = d_in.rcase;
        d_next.dv    = d_in.dv;
        d_next.n1    = v1[NUM_W] ? NUM_W'(-v1) : NUM_W'(v1);
        d_next.n2    = v2[NUM_W] ? NUM_W'(-v2) : NUM_W'(v2);
        d_next.neg1  = v1[NUM_W] ^ d_in.dv_neg;
        d_next.neg2  = v2[NUM_W] ^ d_in.dv_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign vld   = vld_reg;
    assign d_out = d_reg;

endmodule

[sv/qrs_div_cell.sv]
// qrs_div_cell: one quotient bit of restoring division, two lanes
// depends on qrs_pkg
module qrs_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  qrs_pkg::dvc_t d_in,
    output logic          vld,
    output qrs_pkg::dvc_t d_out
);
    import qrs_pkg::*;

    logic               vld_reg;
    dvc_t               d_reg, d_next;
    logic [DIV_W:0]     sh1, sh2, dvx, df1, df2;
    logic               ge1, ge2;

    always_comb
    begin
        dvx = {1'b0, d_in.dv};
        sh1 = {d_in.r1, d_in.n1[NUM_W-1]};
        sh2 = {d_in.r2, d_in.n2[NUM_W-1]};
        df1 = sh1 - dvx;
        df2 = sh2 - dvx;
        ge1 = sh1 >= dvx;
        ge2 = sh2 >= dvx;
        d_next    = d_in;
        d_next.r1 = ge1 ? df1[DIV_W-1:0] : sh1[DIV_W-1:0];
        d_next.r2 = ge2 ? df2[DIV_W-1:0] : sh2[DIV_W-1:0];
        // numerator shifts out at the top, quotient shifts in at the bottom
        d_next.n1 = {d_in.n1[NUM_W-2:0], ge1};
        d_next.n2 = {d_in.n2[NUM_W-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign vld   = vld_reg;
    assign d_out = d_reg;

endmodule

[sv/qrs_back.sv]
// qrs_back: sign, saturation, overflow and output registers
// depends on qrs_pkg
module qrs_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  vld_in,
    input  qrs_pkg::dvc_t                         d_in,
    output logic                                  done,
    output logic [1:0]                            root_case,
    output logic signed [qrs_pkg::WORD_BITS-1:0]  root_first,
    output logic signed [qrs_pkg::WORD_BITS-1:0]  root_second,
    output logic                                  overflow
);
    import qrs_pkg::*;

    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(64'd1 << (WORD_BITS - 1));
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);

    logic                  done_reg;
    logic [1:0]            case_reg;
    logic [WORD_BITS-1:0]  r1_reg, r2_reg, r1_next, r2_next;
    logic                  ov_reg, ov_next, ov1, ov2, live;

    function automatic logic [WORD_BITS:0] sat(input logic [NUM_W-1:0] q, input logic sgn);
        logic neg;
        neg = (q != '0) && sgn;
        if (neg)
        begin
            if (q > NEG_LIM)
                sat = {1'b1, NEG_LIM[WORD_BITS-1:0]};
            else
                sat = {1'b0, -q[WORD_BITS-1:0]};
        end
        else
        begin
            if (q > POS_LIM)
                sat = {1'b1, POS_LIM[WORD_BITS-1:0]};
            else
                sat = {1'b0, q[WORD_BITS-1:0]};
        end
    endfunction

    always_comb
    begin
        live = (d_in.rcase == CASE_ONE) || (d_in.rcase == CASE_TWO);
        {ov1, r1_next} = sat(d_in.n1, d_in.neg1);
        {ov2, r2_next} = sat(d_in.n2, d_in.neg2);
        ov_next = live && (ov1 || ov2);
        if (!live)
        begin
            r1_next = '0;
            r2_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        case_reg <= d_in.rcase;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        ov_reg   <= ov_next;
    end

    assign done        = done_reg;
    assign root_case   = case_reg;
    assign root_first  = $signed(r1_reg);
    assign root_second = $signed(r2_reg);
    assign overflow    = ov_reg;

endmodule

[sv/quadratic_root_solver.sv]
// quadratic_root_solver: top level, front end, square root cell row, join, divider cell row, output
// depends on qrs_pkg, qrs_front, qrs_sqrt_cell, qrs_join, qrs_div_cell, qrs_back
//
//   channel   signals                               handshake
//   ------    ----------------------------------    ---------------------------------
//   item in   coef_a, coef_b, coef_c                start high and busy low at clk edge
//   result    root_case, root_first, root_second,   done high for exactly one cycle
//             overflow
//
// fully pipelined: one item per cycle, busy stays low
// pipeline stages: 2 front stages, 49 square root cells (one root bit each),
// 1 join stage, 50 divider cells (one quotient bit each, both roots in parallel),
// 1 output stage
// reset clears only the valid bits along the chain; results cannot be held off
module quadratic_root_solver (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_a,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_b,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_c,
    output logic                                  done,
    output logic [1:0]                            root_case,
    output logic signed [qrs_pkg::WORD_BITS-1:0]  root_first,
    output logic signed [qrs_pkg::WORD_BITS-1:0]  root_second,
    output logic                                  overflow
);
    import qrs_pkg::*;

    // square root row: index 0 is the front end output
    logic sq_vld [SQRT_W+1];
    sqc_t sq_d   [SQRT_W+1];

    // divider row: index 0 is the join output
    logic dv_vld [NUM_W+1];
    dvc_t dv_d   [NUM_W+1];

    // every stage moves each cycle, nothing to wait for
    assign busy = 1'b0;

    qrs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .coef_a (coef_a),
        .coef_b (coef_b),
        .coef_c (coef_c),
        .vld    (sq_vld[0]),
        .data   (sq_d[0])
    );

    // one root bit per cell, radicand pairs shift out of the top
    for (genvar i = 0; i < SQRT_W; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .vld_in (sq_vld[i]),
            .d_in   (sq_d[i]),
            .vld    (sq_vld[i+1]),
            .d_out  (sq_d[i+1])
        );
    end

    // numerators -b*2^F -/+ sqrt, sign of each quotient
    qrs_join u_join (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld_in (sq_vld[SQRT_W]),
        .d_in   (sq_d[SQRT_W]),
        .vld    (dv_vld[0]),
        .d_out  (dv_d[0])
    );

    // one quotient bit per cell for both roots
    for (genvar j = 0; j < NUM_W; j++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .vld_in (dv_vld[j]),
            .d_in   (dv_d[j]),
            .vld    (dv_vld[j+1]),
            .d_out  (dv_d[j+1])
        );
    end

    // clamp to the word range and flag overflow
    qrs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .vld_in      (dv_vld[NUM_W]),
        .d_in        (dv_d[NUM_W]),
        .done        (done),
        .root_case   (root_case),
        .root_first  (root_first),
        .root_second (root_second),
        .overflow    (overflow)
    );

endmodule

[sv/qrs_checker.sv]
// qrs_checker: port-level assertions for the quadratic root solver, with its bind
// depends on qrs_pkg and quadratic_root_solver
module qrs_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_a,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_b,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_c,
    input  logic                                  done,
    input  logic [1:0]                            root_case,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  root_first,
    input  logic signed [qrs_pkg::WORD_BITS-1:0]  root_second,
    input  logic                                  overflow
);
    import qrs_pkg::*;

    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after pipeline latency");

    // no root reported: both roots zero and no overflow
    a_no_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (root_case == CASE_NONE || root_case == CASE_INF)) |->
        (root_first == '0 && root_second == '0 && !overflow))
        else $error("roots or overflow set without a root");

    // a single root is reported twice
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && root_case == CASE_ONE) |-> (root_first == root_second))
        else $error("single root differs between outputs");

    // infinitely many roots exactly when all coefficients were zero
    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((root_case == CASE_INF) ==
        $past(coef_a == '0 && coef_b == '0 && coef_c == '0, LATENCY)))
        else $error("infinite case does not match zero coefficients");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .coef_c      (coef_c),
    .done        (done),
    .root_case   (root_case),
    .root_first  (root_first),
    .root_second (root_second),
    .overflow    (overflow)
);
